FILE: rtl/dadd_pkg.sv
// Shared constants, types and calendar functions for the date adder.
package dadd_pkg;

   localparam int DAY_W          = 5;
   localparam int MON_W          = 4;
   localparam int YEAR_W         = 14;
   localparam int DAYS_WIDTH_DEF = 16;

   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd16383;

   localparam logic [MON_W-1:0] MON_JAN = 4'd1;
   localparam logic [MON_W-1:0] MON_FEB = 4'd2;
   localparam logic [MON_W-1:0] MON_DEC = 4'd12;

   localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0] DAY_LAST  = 5'd31;

   // Division by 100 as a multiply by 5243 / 2^19, exact for all 14-bit years.
   localparam logic [12:0] CENT_RECIP = 13'd5243;
   localparam int          CENT_SHIFT = 19;
   localparam logic [6:0]  CENT       = 7'd100;
   localparam logic [6:0]  CENT_LAST  = 7'd99;

   typedef struct packed {
      logic div;
      logic rem;
      logic inc;
   } yctl_type;

   typedef struct packed {
      logic             adv;
      logic             wrap;
      logic [DAY_W-1:0] d_next;
      logic [MON_W-1:0] m_next;
   } step_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         MON_FEB:                                   len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/dadd_year.sv
// Year tracker: splits the start year by 100 and keeps the leap flag as the year advances.
module dadd_year (
   input  logic                           clock,
   input  logic                           reset,
   input  dadd_pkg::yctl_type             ctl,
   input  logic [dadd_pkg::YEAR_W-1:0]    year,
   output logic                           leap
);
   import dadd_pkg::*;

   logic [YEAR_W+12:0] prod;
   logic [7:0]         q_ff, q_in;
   logic [14:0]        qx100;
   logic [YEAR_W-1:0]  rem_full;
   logic [6:0]         yr100_ff, yr100_in;
   logic [1:0]         cen4_ff, cen4_in;

   assign prod     = {{13{1'b0}}, year} * {{YEAR_W{1'b0}}, CENT_RECIP};
   assign qx100    = {7'd0, q_ff} * {8'd0, CENT};
   assign rem_full = year - qx100[YEAR_W-1:0];

   always_comb begin
      q_in     = q_ff;
      yr100_in = yr100_ff;
      cen4_in  = cen4_ff;
      if (ctl.div) begin
         q_in = prod[CENT_SHIFT+7:CENT_SHIFT];
      end
      if (ctl.rem) begin
         yr100_in = rem_full[6:0];
         cen4_in  = q_ff[1:0];
      end else if (ctl.inc) begin
         if (yr100_ff == CENT_LAST) begin
            yr100_in = 7'd0;
            cen4_in  = cen4_ff + 2'd1;
         end else begin
            yr100_in = yr100_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff     <= '0;
         yr100_ff <= '0;
         cen4_ff  <= '0;
      end else begin
         q_ff     <= q_in;
         yr100_ff <= yr100_in;
         cen4_ff  <= cen4_in;
      end
   end

   assign leap = (year[1:0] == 2'd0) && ((yr100_ff != 7'd0) || (cen4_ff == 2'd0));

endmodule

FILE: rtl/dadd_step.sv
// Month step unit: one subtract and compare that either finishes the month or jumps to the next.
module dadd_step #(
   parameter int DAYS_WIDTH = dadd_pkg::DAYS_WIDTH_DEF
) (
   input  logic [dadd_pkg::DAY_W-1:0] day,
   input  logic [dadd_pkg::MON_W-1:0] month,
   input  logic                       leap,
   input  logic [DAYS_WIDTH-1:0]      days,
   output dadd_pkg::step_type         step,
   output logic [DAYS_WIDTH-1:0]      days_next
);
   import dadd_pkg::*;

   logic [DAY_W-1:0]      len;
   logic [DAY_W:0]        to_next;
   logic [DAYS_WIDTH-1:0] to_next_x;

   assign len       = month_days(month, leap);
   assign to_next   = {1'b0, len} - {1'b0, day} + 6'd1;
   assign to_next_x = {{(DAYS_WIDTH-DAY_W-1){1'b0}}, to_next};

   always_comb begin
      step.adv  = days >= to_next_x;
      step.wrap = step.adv && (month == MON_DEC);
      if (step.adv) begin
         step.d_next = DAY_FIRST;
         step.m_next = (month == MON_DEC) ? MON_JAN : month + 4'd1;
         days_next   = days - to_next_x;
      end else begin
         step.d_next = day + days[DAY_W-1:0];
         step.m_next = month;
         days_next   = '0;
      end
   end

endmodule

FILE: rtl/date_add_days.sv
// Top level of the Gregorian date adder: sequencer around the month step unit.
//
//   Channel   Ports                            Handshake
//   request   start, busy, req_*               taken when start is high and busy is low
//   result    rsp_valid, rsp_*                 one-cycle strobe, always taken
//
// An invalid date keeps busy high through DIV, REM, CHK and OUT, the last being the result
// strobe. Any other request goes through DIV, REM and CHK into RUN, where each step crosses
// a month boundary or ends the count in a month, then OUT once the count is zero or the
// year saturates. DIV and REM split the start year by 100 in the year tracker's multiplier.
// Reset is synchronous and returns the sequencer to idle. The receiver cannot stall.
module date_add_days #(
   parameter int DAYS_WIDTH = dadd_pkg::DAYS_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dadd_pkg::DAY_W-1:0]     req_start_day,
   input  logic [dadd_pkg::MON_W-1:0]     req_start_month,
   input  logic [dadd_pkg::YEAR_W-1:0]    req_start_year,
   input  logic [DAYS_WIDTH-1:0]          req_days_to_add,
   output logic                           rsp_valid,
   output logic [dadd_pkg::DAY_W-1:0]     rsp_end_day,
   output logic [dadd_pkg::MON_W-1:0]     rsp_end_month,
   output logic [dadd_pkg::YEAR_W-1:0]    rsp_end_year,
   output logic                           rsp_invalid_date,
   output logic                           rsp_year_overflow
);
   import dadd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_REM  = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_RUN  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [DAY_W-1:0]      day_ff, day_in;
   logic [MON_W-1:0]      mon_ff, mon_in;
   logic [YEAR_W-1:0]     year_ff, year_in;
   logic [DAYS_WIDTH-1:0] days_ff, days_in;
   logic                  inv_ff, inv_in;
   logic                  ovf_ff, ovf_in;

   yctl_type              yctl;
   logic                  leap;
   step_type              step;
   logic [DAYS_WIDTH-1:0] days_next;
   logic                  bad_date;

   dadd_year u_year (
      .clock (clock),
      .reset (reset),
      .ctl   (yctl),
      .year  (year_ff),
      .leap  (leap)
   );

   dadd_step #(.DAYS_WIDTH(DAYS_WIDTH)) u_step (
      .day       (day_ff),
      .month     (mon_ff),
      .leap      (leap),
      .days      (days_ff),
      .step      (step),
      .days_next (days_next)
   );

   assign bad_date = (day_ff == '0) || (mon_ff == '0) || (mon_ff > MON_DEC) ||
                     (day_ff > month_days(mon_ff, leap));

   always_comb begin
      state_in = state_ff;
      day_in   = day_ff;
      mon_in   = mon_ff;
      year_in  = year_ff;
      days_in  = days_ff;
      inv_in   = inv_ff;
      ovf_in   = ovf_ff;
      yctl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               day_in   = req_start_day;
               mon_in   = req_start_month;
               year_in  = req_start_year;
               days_in  = req_days_to_add;
               inv_in   = 1'b0;
               ovf_in   = 1'b0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            yctl.div = 1'b1;
            state_in = S_REM;
         end
         S_REM: begin
            yctl.rem = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (bad_date) begin
               inv_in   = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (days_ff == '0) begin
               state_in = S_OUT;
            end else if (step.wrap && (year_ff == YEAR_MAX)) begin
               ovf_in   = 1'b1;
               day_in   = DAY_LAST;
               mon_in   = MON_DEC;
               year_in  = YEAR_MAX;
               state_in = S_OUT;
            end else begin
               day_in   = step.d_next;
               mon_in   = step.m_next;
               days_in  = days_next;
               if (step.wrap) begin
                  year_in  = year_ff + 14'd1;
                  yctl.inc = 1'b1;
               end
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff  <= day_in;
      mon_ff  <= mon_in;
      year_ff <= year_in;
      days_ff <= days_in;
      inv_ff  <= inv_in;
      ovf_ff  <= ovf_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = (state_ff == S_OUT);
   assign rsp_end_day       = day_ff;
   assign rsp_end_month     = mon_ff;
   assign rsp_end_year      = year_ff;
   assign rsp_invalid_date  = inv_ff;
   assign rsp_year_overflow = ovf_ff;

endmodule

FILE: rtl/dadd_check.sv
// Port-level checker for the date adder, bound to the top level.
module dadd_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [dadd_pkg::DAY_W-1:0]  rsp_end_day,
   input logic [dadd_pkg::MON_W-1:0]  rsp_end_month,
   input logic [dadd_pkg::YEAR_W-1:0] rsp_end_year,
   input logic                        rsp_invalid_date,
   input logic                        rsp_year_overflow
);
   import dadd_pkg::*;

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid_date) |-> !rsp_year_overflow)
      else $error("invalid date and overflow flagged together");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_year_overflow) |->
         (rsp_end_day == DAY_LAST) && (rsp_end_month == MON_DEC) &&
         (rsp_end_year == YEAR_MAX))
      else $error("overflow result not saturated");

endmodule

bind date_add_days dadd_check u_dadd_check (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_end_day       (rsp_end_day),
   .rsp_end_month     (rsp_end_month),
   .rsp_end_year      (rsp_end_year),
   .rsp_invalid_date  (rsp_invalid_date),
   .rsp_year_overflow (rsp_year_overflow)
);

FILE: verif/date_add_days_checker.sv
// Checker for the date adder: predicts each result from the requests it sees and compares.
`timescale 1ns / 1ps

module date_add_days_checker #(
   parameter int DAYS_WIDTH = dadd_pkg::DAYS_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [dadd_pkg::DAY_W-1:0]  req_start_day,
   input  logic [dadd_pkg::MON_W-1:0]  req_start_month,
   input  logic [dadd_pkg::YEAR_W-1:0] req_start_year,
   input  logic [DAYS_WIDTH-1:0]       req_days_to_add,
   input  logic                        rsp_valid,
   input  logic [dadd_pkg::DAY_W-1:0]  rsp_end_day,
   input  logic [dadd_pkg::MON_W-1:0]  rsp_end_month,
   input  logic [dadd_pkg::YEAR_W-1:0] rsp_end_year,
   input  logic                        rsp_invalid_date,
   input  logic                        rsp_year_overflow,
   output int                          mismatch_count,
   output int                          dates_in_flight
);

   localparam int unsigned MONTH_JAN = 32'(dadd_pkg::MON_JAN);
   localparam int unsigned MONTH_DEC = 32'(dadd_pkg::MON_DEC);
   localparam int unsigned FIRST_DAY = 32'(dadd_pkg::DAY_FIRST);
   localparam int unsigned LAST_DAY  = 32'(dadd_pkg::DAY_LAST);
   localparam int unsigned YEAR_TOP  = 32'(dadd_pkg::YEAR_MAX);

   typedef struct packed {
      logic [dadd_pkg::DAY_W-1:0]  day;
      logic [dadd_pkg::MON_W-1:0]  month;
      logic [dadd_pkg::YEAR_W-1:0] year;
      logic                        invalid;
      logic                        overflow;
   } date_outcome_type;

   date_outcome_type awaited_dates[$];
   date_outcome_type seen_date;
   date_outcome_type wanted_date;

   function automatic logic year_is_leap(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return year_is_leap(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic date_outcome_type predict_date(
      input logic [dadd_pkg::DAY_W-1:0]  start_day,
      input logic [dadd_pkg::MON_W-1:0]  start_month,
      input logic [dadd_pkg::YEAR_W-1:0] start_year,
      input logic [DAYS_WIDTH-1:0]       days_to_add
   );
      int unsigned      d;
      int unsigned      m;
      int unsigned      y;
      int unsigned      n;
      int unsigned      to_next;
      date_outcome_type r;
      d = 32'(start_day);
      m = 32'(start_month);
      y = 32'(start_year);
      n = 32'(days_to_add);
      r.invalid  = 1'b0;
      r.overflow = 1'b0;
      if (d == 0 || m == 0 || m > MONTH_DEC || d > month_length(m, y)) begin
         r.invalid = 1'b1;
      end else begin
         while (n > 0) begin
            to_next = month_length(m, y) - d + 1;
            if (n >= to_next) begin
               n = n - to_next;
               d = FIRST_DAY;
               if (m == MONTH_DEC) begin
                  if (y >= YEAR_TOP) begin
                     r.overflow = 1'b1;
                     d = LAST_DAY;
                     m = MONTH_DEC;
                     y = YEAR_TOP;
                     n = 0;
                  end else begin
                     m = MONTH_JAN;
                     y = y + 1;
                  end
               end else begin
                  m = m + 1;
               end
            end else begin
               d = d + n;
               n = 0;
            end
         end
      end
      r.day   = d[dadd_pkg::DAY_W-1:0];
      r.month = m[dadd_pkg::MON_W-1:0];
      r.year  = y[dadd_pkg::YEAR_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         awaited_dates.delete();
         mismatch_count  <= 0;
         dates_in_flight <= 0;
      end else begin
         if (rsp_valid) begin
            seen_date = '{rsp_end_day, rsp_end_month, rsp_end_year,
                          rsp_invalid_date, rsp_year_overflow};
            if (awaited_dates.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("unexpected result: %0d-%0d-%0d invalid %0b overflow %0b",
                           seen_date.year, seen_date.month, seen_date.day,
                           seen_date.invalid, seen_date.overflow);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               wanted_date = awaited_dates.pop_front();
               if (seen_date !== wanted_date) begin
                  if (mismatch_count < 10) begin
                     $display({"mismatch: expected %0d-%0d-%0d invalid %0b overflow %0b,",
                               " got %0d-%0d-%0d invalid %0b overflow %0b"},
                              wanted_date.year, wanted_date.month, wanted_date.day,
                              wanted_date.invalid, wanted_date.overflow,
                              seen_date.year, seen_date.month, seen_date.day,
                              seen_date.invalid, seen_date.overflow);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (start && !busy) begin
            awaited_dates.push_back(predict_date(req_start_day, req_start_month,
                                                 req_start_year, req_days_to_add));
         end
         dates_in_flight <= awaited_dates.size();
      end
   end

endmodule

FILE: verif/tb.sv
// Testbench top for the date adder: drives requests in bursts and reports the verdict.
`timescale 1ns / 1ps

module tb;

   localparam int DAYS_W          = dadd_pkg::DAYS_WIDTH_DEF;
   localparam int DAY_W           = dadd_pkg::DAY_W;
   localparam int MON_W           = dadd_pkg::MON_W;
   localparam int YEAR_W          = dadd_pkg::YEAR_W;
   localparam int RANDOM_REQUESTS = 250;
   localparam int DRAIN_CYCLES    = 2200;
   localparam int CYCLE_LIMIT     = 4_000_000;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [dadd_pkg::DAY_W-1:0]  req_start_day;
   logic [dadd_pkg::MON_W-1:0]  req_start_month;
   logic [dadd_pkg::YEAR_W-1:0] req_start_year;
   logic [DAYS_W-1:0]           req_days_to_add;
   logic                        rsp_valid;
   logic [dadd_pkg::DAY_W-1:0]  rsp_end_day;
   logic [dadd_pkg::MON_W-1:0]  rsp_end_month;
   logic [dadd_pkg::YEAR_W-1:0] rsp_end_year;
   logic                        rsp_invalid_date;
   logic                        rsp_year_overflow;

   int mismatch_count;
   int dates_in_flight;
   int cycle_count = 0;
   int burst_left  = 0;

   date_add_days #(.DAYS_WIDTH(DAYS_W)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_start_day     (req_start_day),
      .req_start_month   (req_start_month),
      .req_start_year    (req_start_year),
      .req_days_to_add   (req_days_to_add),
      .rsp_valid         (rsp_valid),
      .rsp_end_day       (rsp_end_day),
      .rsp_end_month     (rsp_end_month),
      .rsp_end_year      (rsp_end_year),
      .rsp_invalid_date  (rsp_invalid_date),
      .rsp_year_overflow (rsp_year_overflow)
   );

   date_add_days_checker #(.DAYS_WIDTH(DAYS_W)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_start_day     (req_start_day),
      .req_start_month   (req_start_month),
      .req_start_year    (req_start_year),
      .req_days_to_add   (req_days_to_add),
      .rsp_valid         (rsp_valid),
      .rsp_end_day       (rsp_end_day),
      .rsp_end_month     (rsp_end_month),
      .rsp_end_year      (rsp_end_year),
      .rsp_invalid_date  (rsp_invalid_date),
      .rsp_year_overflow (rsp_year_overflow),
      .mismatch_count    (mismatch_count),
      .dates_in_flight   (dates_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_request(input logic [dadd_pkg::DAY_W-1:0]  d,
                               input logic [dadd_pkg::MON_W-1:0]  m,
                               input logic [dadd_pkg::YEAR_W-1:0] y,
                               input logic [DAYS_W-1:0]           n);
      start           <= 1'b1;
      req_start_day   <= d;
      req_start_month <= m;
      req_start_year  <= y;
      req_days_to_add <= n;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(0, 8);
      end else begin
         burst_left = burst_left - 1;
      end
   endtask

   task automatic send_random_request();
      logic [dadd_pkg::DAY_W-1:0]  d;
      logic [dadd_pkg::MON_W-1:0]  m;
      logic [dadd_pkg::YEAR_W-1:0] y;
      logic [DAYS_W-1:0]           n;
      int unsigned                 pick;
      pick = $urandom_range(0, 99);
      m = MON_W'((pick < 90) ? $urandom_range(1, 12) : $urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      d = DAY_W'((pick < 70) ? $urandom_range(1, 28) : $urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         y = YEAR_W'($urandom_range(0, 16383));
      end else if (pick < 60) begin
         y = YEAR_W'($urandom_range(0, 163) * 100);
      end else if (pick < 80) begin
         y = YEAR_W'($urandom_range(16300, 16383));
      end else begin
         y = YEAR_W'($urandom_range(1890, 2110));
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         n = DAYS_W'($urandom_range(0, 400));
      end else if (pick < 75) begin
         n = DAYS_W'($urandom_range(0, 4000));
      end else if (pick < 90) begin
         n = DAYS_W'($urandom_range(0, 65535));
      end else begin
         n = $urandom_range(0, 1) ? '1 : '0;
      end
      send_request(d, m, y, n);
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_start_day   = '0;
      req_start_month = '0;
      req_start_year  = '0;
      req_days_to_add = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_request(5'd1, 4'd1, 14'd0, 16'd0);
      send_request(5'd1, 4'd1, 14'd0, 16'hffff);
      send_request(5'd31, 4'd12, 14'd16383, 16'd0);
      send_request(5'd31, 4'd12, 14'd16383, 16'd1);
      send_request(5'd1, 4'd12, 14'd16383, 16'd30);
      send_request(5'd1, 4'd12, 14'd16383, 16'd31);
      send_request(5'd1, 4'd1, 14'd16383, 16'hffff);
      send_request(5'd0, 4'd5, 14'd2020, 16'd10);
      send_request(5'd10, 4'd0, 14'd2020, 16'd10);
      send_request(5'd10, 4'd13, 14'd2020, 16'd10);
      send_request(5'd31, 4'd15, 14'd16383, 16'hffff);
      send_request(5'd31, 4'd4, 14'd2021, 16'd1);
      send_request(5'd29, 4'd2, 14'd1900, 16'd1);
      send_request(5'd29, 4'd2, 14'd2000, 16'd1);
      send_request(5'd29, 4'd2, 14'd2024, 16'd365);
      send_request(5'd28, 4'd2, 14'd2100, 16'd1);
      send_request(5'd28, 4'd2, 14'd2400, 16'd1);
      send_request(5'd31, 4'd12, 14'd1999, 16'd1);
      send_request(5'd31, 4'd1, 14'd2023, 16'd1);
      send_request(5'd30, 4'd1, 14'd2023, 16'd1);
      send_request(5'd15, 4'd6, 14'd2023, 16'd16);
      send_request(5'd30, 4'd11, 14'd8191, 16'd32768);

      repeat (RANDOM_REQUESTS) send_random_request();

      start <= 1'b0;
      @(posedge clock);
      while (dates_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/dadd_pkg.sv
rtl/dadd_year.sv
rtl/dadd_step.sv
rtl/date_add_days.sv
rtl/dadd_check.sv
verif/date_add_days_checker.sv
verif/tb.sv
